// ===== rtl/uwh_pkg.sv =====
package uwh_pkg;

    localparam int unsigned LENGTH_WIDTH = 16;
    localparam int unsigned ADDR_WIDTH   = 32;
    localparam int unsigned CNT_WIDTH    = 16;

    localparam logic [CNT_WIDTH-1:0] DEFAULT_ACK_TIMEOUT = CNT_WIDTH'(100);
    localparam logic [CNT_WIDTH-1:0] CNT_MAX             = '1;

    localparam logic [2:0] CMD_SEND_REQ  = 3'd0;
    localparam logic [2:0] CMD_REQ_FELL  = 3'd1;
    localparam logic [2:0] CMD_SEND_DONE = 3'd2;
    localparam logic [2:0] CMD_RDY_ROSE  = 3'd3;
    localparam logic [2:0] CMD_RDY_FELL  = 3'd4;
    localparam logic [2:0] CMD_MS_TICK   = 3'd5;

    localparam logic [1:0] PIN_LOW      = 2'd0;
    localparam logic [1:0] PIN_RELEASED = 2'd1;
    localparam logic [1:0] PIN_HIGH     = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_WAIT   = 2'd1,
        PH_ACTIVE = 2'd2
    } phase_t;

    typedef struct packed {
        logic [2:0]              cmd;
        logic [ADDR_WIDTH-1:0]   buffer_address;
        logic [LENGTH_WIDTH-1:0] transfer_length;
        logic                    send_ok;
    } in_item_t;

    typedef struct packed {
        logic                    accepted;
        logic [1:0]              req_pin;
        logic                    rdy_pulse_low;
        logic                    rdy_watch_rising;
        logic                    rx_enable;
        logic [LENGTH_WIDTH-1:0] send_length;
        logic [ADDR_WIDTH-1:0]   send_address;
        logic [1:0]              tx_state;
        logic [CNT_WIDTH-1:0]    unexpected_count;
        logic [CNT_WIDTH-1:0]    send_error_count;
        logic [CNT_WIDTH-1:0]    ack_timeout_count;
        logic [CNT_WIDTH-1:0]    request_count;
    } out_item_t;

    function automatic logic [CNT_WIDTH-1:0] sat_inc(input logic [CNT_WIDTH-1:0] v);
        logic [CNT_WIDTH-1:0] r;
        r = (v == CNT_MAX) ? CNT_MAX : v + CNT_WIDTH'(1);
        return r;
    endfunction

endpackage

// ===== rtl/uart_wake_handshake_controller.sv =====
// Request/ready handshake controller for a low-power UART link. Each input item is one
// event (send request, request wire fell, send done, ready rose, ready fell, 1 ms tick)
// and produces exactly one result item carrying the wire drive levels, the ready edge to
// watch, receive enable, a send start (nonzero send_length), the send state and four
// saturating counters. Items flow through an input register and a result register with
// combinational logic between them: one item per clock sustained while out_ready is high;
// the result register loads from the input register; out_ready low stalls the result
// register and backs up into in_ready. cfg_we loads the acknowledge timeout in ms ticks
// (0 selects 100) and should only be used while no items are in flight.
module uart_wake_handshake_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  uwh_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output uwh_pkg::out_item_t            out_data,
    input  logic                          cfg_we,
    input  logic [uwh_pkg::CNT_WIDTH-1:0] cfg_data
);
    import uwh_pkg::*;

    logic     item_valid;
    logic     item_take;
    in_item_t item_data;

    uwh_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item_data  (item_data)
    );

    uwh_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item_data  (item_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

// ===== rtl/uwh_in_stage.sv =====
module uwh_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  uwh_pkg::in_item_t in_data,
    output logic              item_valid,
    input  logic              item_take,
    output uwh_pkg::in_item_t item_data
);
    import uwh_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t data_reg;

    assign in_ready   = !valid_reg || item_take;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (item_take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

    assign item_valid = valid_reg;
    assign item_data  = data_reg;

endmodule

// ===== rtl/uwh_core.sv =====
module uwh_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [uwh_pkg::CNT_WIDTH-1:0]   cfg_data,
    input  logic                            item_valid,
    output logic                            item_take,
    input  uwh_pkg::in_item_t               item_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output uwh_pkg::out_item_t              out_data
);
    import uwh_pkg::*;

    phase_t                  phase_reg,     phase_next;
    logic                    rx_reg,        rx_next;
    logic                    watch_reg,     watch_next;
    logic [CNT_WIDTH-1:0]    elapsed_reg,   elapsed_next;
    logic [ADDR_WIDTH-1:0]   addr_reg,      addr_next;
    logic [LENGTH_WIDTH-1:0] len_reg,       len_next;
    logic [CNT_WIDTH-1:0]    stray_reg,     stray_next;
    logic [CNT_WIDTH-1:0]    refused_reg,   refused_next;
    logic [CNT_WIDTH-1:0]    timeouts_reg,  timeouts_next;
    logic [CNT_WIDTH-1:0]    peer_reg,      peer_next;
    logic [CNT_WIDTH-1:0]    timeout_reg,   timeout_next;
    logic                    out_valid_reg, out_valid_next;
    out_item_t               out_data_reg,  out_data_next;

    logic                    accepted;
    logic                    pulse;
    logic [LENGTH_WIDTH-1:0] s_len;
    logic [ADDR_WIDTH-1:0]   s_addr;
    logic [CNT_WIDTH-1:0]    elapsed_inc;

    assign item_take   = item_valid && (!out_valid_reg || out_ready);
    assign elapsed_inc = sat_inc(elapsed_reg);

    always_comb
    begin
        phase_next    = phase_reg;
        rx_next       = rx_reg;
        watch_next    = watch_reg;
        elapsed_next  = elapsed_reg;
        addr_next     = addr_reg;
        len_next      = len_reg;
        stray_next    = stray_reg;
        refused_next  = refused_reg;
        timeouts_next = timeouts_reg;
        peer_next     = peer_reg;
        accepted      = 1'b0;
        pulse         = 1'b0;
        s_len         = '0;
        s_addr        = '0;

        unique case (item_data.cmd)
            CMD_SEND_REQ:
            begin
                if (item_data.transfer_length != '0 && phase_reg == PH_IDLE)
                begin
                    addr_next    = item_data.buffer_address;
                    len_next     = item_data.transfer_length;
                    elapsed_next = '0;
                    phase_next   = PH_WAIT;
                    accepted     = 1'b1;
                end
            end
            CMD_REQ_FELL:
            begin
                if (phase_reg != PH_WAIT)
                begin
                    stray_next = sat_inc(stray_reg);
                end
                else if (item_data.send_ok)
                begin
                    phase_next = PH_ACTIVE;
                    s_len      = len_reg;
                    s_addr     = addr_reg;
                end
                else
                begin
                    refused_next = sat_inc(refused_reg);
                    phase_next   = PH_IDLE;
                    elapsed_next = '0;
                    addr_next    = '0;
                    len_next     = '0;
                end
            end
            CMD_SEND_DONE:
            begin
                if (phase_reg != PH_ACTIVE)
                begin
                    stray_next = sat_inc(stray_reg);
                end
                else
                begin
                    phase_next   = PH_IDLE;
                    elapsed_next = '0;
                    addr_next    = '0;
                    len_next     = '0;
                end
            end
            CMD_RDY_ROSE:
            begin
                if (rx_reg)
                begin
                    stray_next = sat_inc(stray_reg);
                end
                else
                begin
                    rx_next    = 1'b1;
                    pulse      = 1'b1;
                    peer_next  = sat_inc(peer_reg);
                    watch_next = 1'b0;
                end
            end
            CMD_RDY_FELL:
            begin
                if (!rx_reg)
                begin
                    stray_next = sat_inc(stray_reg);
                end
                rx_next    = 1'b0;
                watch_next = 1'b1;
            end
            CMD_MS_TICK:
            begin
                if (phase_reg == PH_WAIT)
                begin
                    if (elapsed_inc >= timeout_reg)
                    begin
                        timeouts_next = sat_inc(timeouts_reg);
                        phase_next    = PH_IDLE;
                        elapsed_next  = '0;
                        addr_next     = '0;
                        len_next      = '0;
                    end
                    else
                    begin
                        elapsed_next = elapsed_inc;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_data_next.accepted          = accepted;
        unique case (phase_next)
            PH_WAIT:   out_data_next.req_pin = PIN_RELEASED;
            PH_ACTIVE: out_data_next.req_pin = PIN_HIGH;
            default:   out_data_next.req_pin = PIN_LOW;
        endcase
        out_data_next.rdy_pulse_low     = pulse;
        out_data_next.rdy_watch_rising  = watch_next;
        out_data_next.rx_enable         = rx_next;
        out_data_next.send_length       = s_len;
        out_data_next.send_address      = s_addr;
        out_data_next.tx_state          = phase_next;
        out_data_next.unexpected_count  = stray_next;
        out_data_next.send_error_count  = refused_next;
        out_data_next.ack_timeout_count = timeouts_next;
        out_data_next.request_count     = peer_next;
    end

    assign out_valid_next = item_take ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    assign timeout_next   = (cfg_data == '0) ? DEFAULT_ACK_TIMEOUT : cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            rx_reg        <= 1'b0;
            watch_reg     <= 1'b1;
            elapsed_reg   <= '0;
            addr_reg      <= '0;
            len_reg       <= '0;
            stray_reg     <= '0;
            refused_reg   <= '0;
            timeouts_reg  <= '0;
            peer_reg      <= '0;
            timeout_reg   <= DEFAULT_ACK_TIMEOUT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_take)
            begin
                phase_reg    <= phase_next;
                rx_reg       <= rx_next;
                watch_reg    <= watch_next;
                elapsed_reg  <= elapsed_next;
                addr_reg     <= addr_next;
                len_reg      <= len_next;
                stray_reg    <= stray_next;
                refused_reg  <= refused_next;
                timeouts_reg <= timeouts_next;
                peer_reg     <= peer_next;
            end
            if (cfg_we)
            begin
                timeout_reg <= timeout_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // watched ready edge always opposes the receive state
    a_watch_vs_rx: assert property (@(posedge clk) disable iff (!rst_n)
        watch_reg != rx_reg)
        else $error("ready watch edge out of step with receive state");

    // a held transfer exists exactly while the send side is busy
    a_held_len: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) == (len_reg == '0))
        else $error("held length inconsistent with send phase");

    a_accept_wait: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.accepted |-> out_data_reg.tx_state == PH_WAIT)
        else $error("accepted request not waiting for acknowledge");

    a_start_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.send_length != '0 |->
            out_data_reg.tx_state == PH_ACTIVE)
        else $error("send start without active send side");

    a_pulse_rx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.rdy_pulse_low |-> out_data_reg.rx_enable)
        else $error("ready pulse without receiver enabled");

    a_timeout_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        timeout_reg != '0)
        else $error("zero acknowledge timeout loaded");

endmodule

// ===== dv/uwh_link_checker.sv =====
module uwh_link_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  uwh_pkg::in_item_t             in_data,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  uwh_pkg::out_item_t            out_data,
    input  logic                          cfg_we,
    input  logic [uwh_pkg::CNT_WIDTH-1:0] cfg_data,
    output int                            errors,
    output int                            pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import uwh_pkg::*;

    phase_t                  tx_phase;
    logic                    rx_busy;
    logic                    watch_up;
    logic [CNT_WIDTH-1:0]    ticks_waited;
    logic [CNT_WIDTH-1:0]    ack_limit;
    logic [CNT_WIDTH-1:0]    stray_cnt;
    logic [CNT_WIDTH-1:0]    refused_cnt;
    logic [CNT_WIDTH-1:0]    timeout_cnt;
    logic [CNT_WIDTH-1:0]    peer_cnt;
    logic [ADDR_WIDTH-1:0]   held_addr;
    logic [LENGTH_WIDTH-1:0] held_len;
    out_item_t               expected_q[$];

    function automatic logic [CNT_WIDTH-1:0] bump(input logic [CNT_WIDTH-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_WIDTH'(1);
    endfunction

    task automatic release_send();
        tx_phase     = PH_IDLE;
        ticks_waited = '0;
        held_addr    = '0;
        held_len     = '0;
    endtask

    task automatic clear_link();
        release_send();
        rx_busy     = 1'b0;
        watch_up    = 1'b1;
        ack_limit   = DEFAULT_ACK_TIMEOUT;
        stray_cnt   = '0;
        refused_cnt = '0;
        timeout_cnt = '0;
        peer_cnt    = '0;
    endtask

    // Advance the link state by one event and build the result it produces.
    task automatic apply_event(input in_item_t ev, output out_item_t res);
        res = '0;
        case (ev.cmd)
            CMD_SEND_REQ:
            begin
                if (ev.transfer_length != '0 && tx_phase == PH_IDLE)
                begin
                    held_addr    = ev.buffer_address;
                    held_len     = ev.transfer_length;
                    ticks_waited = '0;
                    tx_phase     = PH_WAIT;
                    res.accepted = 1'b1;
                end
            end
            CMD_REQ_FELL:
            begin
                if (tx_phase != PH_WAIT)
                begin
                    stray_cnt = bump(stray_cnt);
                end
                else if (ev.send_ok)
                begin
                    tx_phase         = PH_ACTIVE;
                    res.send_length  = held_len;
                    res.send_address = held_addr;
                end
                else
                begin
                    refused_cnt = bump(refused_cnt);
                    release_send();
                end
            end
            CMD_SEND_DONE:
            begin
                if (tx_phase != PH_ACTIVE)
                    stray_cnt = bump(stray_cnt);
                else
                    release_send();
            end
            CMD_RDY_ROSE:
            begin
                if (rx_busy)
                begin
                    stray_cnt = bump(stray_cnt);
                end
                else
                begin
                    rx_busy           = 1'b1;
                    res.rdy_pulse_low = 1'b1;
                    peer_cnt          = bump(peer_cnt);
                    watch_up          = 1'b0;
                end
            end
            CMD_RDY_FELL:
            begin
                if (!rx_busy)
                    stray_cnt = bump(stray_cnt);
                rx_busy  = 1'b0;
                watch_up = 1'b1;
            end
            CMD_MS_TICK:
            begin
                if (tx_phase == PH_WAIT)
                begin
                    ticks_waited = bump(ticks_waited);
                    if (ticks_waited >= ack_limit)
                    begin
                        timeout_cnt = bump(timeout_cnt);
                        release_send();
                    end
                end
            end
            default:
            begin
            end
        endcase
        case (tx_phase)
            PH_WAIT:   res.req_pin = PIN_RELEASED;
            PH_ACTIVE: res.req_pin = PIN_HIGH;
            default:   res.req_pin = PIN_LOW;
        endcase
        res.rdy_watch_rising  = watch_up;
        res.rx_enable         = rx_busy;
        res.tx_state          = tx_phase;
        res.unexpected_count  = stray_cnt;
        res.send_error_count  = refused_cnt;
        res.ack_timeout_count = timeout_cnt;
        res.request_count     = peer_cnt;
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            errors = errors + 1;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (expected_q.size() == 0)
        begin
            errors = errors + 1;
            $display("%0t: result with nothing expected, expected none, actual %h",
                     $time, got);
        end
        else
        begin
            want = expected_q.pop_front();
            check_field("accepted", 32'(want.accepted), 32'(got.accepted));
            check_field("req_pin", 32'(want.req_pin), 32'(got.req_pin));
            check_field("rdy_pulse_low", 32'(want.rdy_pulse_low), 32'(got.rdy_pulse_low));
            check_field("rdy_watch_rising", 32'(want.rdy_watch_rising),
                        32'(got.rdy_watch_rising));
            check_field("rx_enable", 32'(want.rx_enable), 32'(got.rx_enable));
            check_field("send_length", 32'(want.send_length), 32'(got.send_length));
            check_field("send_address", 32'(want.send_address), 32'(got.send_address));
            check_field("tx_state", 32'(want.tx_state), 32'(got.tx_state));
            check_field("unexpected_count", 32'(want.unexpected_count),
                        32'(got.unexpected_count));
            check_field("send_error_count", 32'(want.send_error_count),
                        32'(got.send_error_count));
            check_field("ack_timeout_count", 32'(want.ack_timeout_count),
                        32'(got.ack_timeout_count));
            check_field("request_count", 32'(want.request_count), 32'(got.request_count));
        end
    endtask

    initial
    begin
        errors  = 0;
        pending = 0;
        clear_link();
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        out_item_t res;
        if (!rst_n)
        begin
            clear_link();
            expected_q.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_we)
                ack_limit = (cfg_data == '0) ? DEFAULT_ACK_TIMEOUT : cfg_data;
            if (out_valid && out_ready)
                check_result(out_data);
            if (in_valid && in_ready)
            begin
                apply_event(in_data, res);
                expected_q.push_back(res);
            end
            pending = expected_q.size();
        end
    end

endmodule

// ===== dv/uart_wake_handshake_controller_tb.sv =====
module uart_wake_handshake_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import uwh_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    in_item_t             in_data;
    logic                 out_valid;
    logic                 out_ready;
    out_item_t            out_data;
    logic                 cfg_we;
    logic [CNT_WIDTH-1:0] cfg_data;

    int          errors;
    int          pending;
    int          cycles    = 0;
    int          sent      = 0;
    bit          calm      = 1'b0;
    int unsigned ack_ticks = 100;

    uart_wake_handshake_controller u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    uwh_link_checker u_chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver stalls
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = calm || ($urandom_range(0, 99) >= 15);
        end
    end

    function automatic in_item_t make_item(input logic [2:0] cmd, input logic [31:0] addr,
                                           input logic [15:0] len, input logic ok);
        in_item_t it;
        it.cmd             = cmd;
        it.buffer_address  = addr;
        it.transfer_length = len;
        it.send_ok         = ok;
        return it;
    endfunction

    function automatic in_item_t random_item(input logic [2:0] cmd);
        return make_item(cmd, $urandom(), 16'($urandom()), 1'($urandom_range(0, 1)));
    endfunction

    function automatic logic [15:0] send_size();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'd1;
        else if (r == 1)
            return 16'hFFFF;
        else
            return 16'($urandom_range(1, 65535));
    endfunction

    // Starts and ends at a falling edge; valid holds until the item is taken.
    task automatic push_event(input in_item_t ev);
        while (!calm && $urandom_range(0, 99) < 15)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = ev;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        in_valid = 1'b0;
        sent = sent + 1;
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_timeout(input logic [CNT_WIDTH-1:0] v);
        drain();
        cfg_data = v;
        cfg_we   = 1'b1;
        @(negedge clk);
        cfg_we    = 1'b0;
        ack_ticks = (v == '0) ? 32'(DEFAULT_ACK_TIMEOUT) : 32'(v);
    endtask

    task automatic tick_run(input int n);
        repeat (n) push_event(random_item(CMD_MS_TICK));
    endtask

    task automatic run_directed();
        push_event(make_item(CMD_SEND_REQ, 32'h1234_5678, 16'd0, 1'b1));   // zero length
        push_event(make_item(CMD_REQ_FELL, 32'h0, 16'h0, 1'b1));           // not waiting
        push_event(make_item(CMD_SEND_DONE, 32'h0, 16'h0, 1'b0));          // not active
        push_event(make_item(CMD_RDY_FELL, 32'hFFFF_FFFF, 16'hFFFF, 1'b1)); // rx idle
        push_event(make_item(CMD_MS_TICK, 32'h0, 16'h0, 1'b0));            // no effect
        push_event(make_item(3'd6, 32'hFFFF_FFFF, 16'hFFFF, 1'b1));
        push_event(make_item(3'd7, 32'hFFFF_FFFF, 16'hFFFF, 1'b1));
        push_event(make_item(CMD_SEND_REQ, 32'hFFFF_FFFF, 16'hFFFF, 1'b0));
        push_event(make_item(CMD_SEND_REQ, 32'h0, 16'd5, 1'b1));           // busy
        push_event(make_item(CMD_MS_TICK, 32'h0, 16'h0, 1'b0));
        push_event(make_item(CMD_SEND_DONE, 32'h0, 16'h0, 1'b0));          // still waiting
        push_event(make_item(CMD_REQ_FELL, 32'h0, 16'h0, 1'b1));
        push_event(make_item(CMD_REQ_FELL, 32'h0, 16'h0, 1'b1));           // already active
        push_event(make_item(CMD_SEND_DONE, 32'h0, 16'h0, 1'b0));
        push_event(make_item(CMD_SEND_REQ, 32'h0, 16'd1, 1'b0));
        push_event(make_item(CMD_REQ_FELL, 32'h0, 16'h0, 1'b0));           // port refuses
        push_event(make_item(CMD_RDY_ROSE, 32'h0, 16'h0, 1'b0));
        push_event(make_item(CMD_RDY_ROSE, 32'h0, 16'h0, 1'b0));           // already active
        push_event(make_item(CMD_RDY_FELL, 32'h0, 16'h0, 1'b0));
        // shortest timeout: first tick gives up
        set_timeout(16'd1);
        push_event(make_item(CMD_SEND_REQ, 32'hA5A5_5A5A, 16'h8000, 1'b1));
        push_event(make_item(CMD_MS_TICK, 32'h0, 16'h0, 1'b0));
        // zero falls back to the default
        set_timeout(16'd0);
    endtask

    task automatic one_sequence();
        int unsigned r;
        int unsigned n;
        r = $urandom_range(0, 9);
        case (r)
            0, 1, 2:
            begin
                push_event(make_item(CMD_SEND_REQ, $urandom(), send_size(), 1'($urandom())));
                n = (ack_ticks > 5) ? 5 : ack_ticks - 1;
                tick_run($urandom_range(0, n));
                push_event(make_item(CMD_REQ_FELL, $urandom(), 16'($urandom()), 1'b1));
                if ($urandom_range(0, 2) == 0)
                begin
                    push_event(random_item(CMD_RDY_ROSE));
                    push_event(random_item(CMD_RDY_FELL));
                end
                tick_run($urandom_range(0, 2));
                push_event(random_item(CMD_SEND_DONE));
            end
            3:
            begin
                push_event(make_item(CMD_SEND_REQ, $urandom(), send_size(), 1'($urandom())));
                push_event(make_item(CMD_REQ_FELL, $urandom(), 16'($urandom()), 1'b0));
            end
            4:
            begin
                push_event(make_item(CMD_SEND_REQ, $urandom(), send_size(), 1'($urandom())));
                if (ack_ticks <= 120)
                begin
                    tick_run(ack_ticks);
                end
                else
                begin
                    tick_run($urandom_range(1, 20));
                    push_event(random_item(CMD_REQ_FELL));
                    push_event(random_item(CMD_SEND_DONE));
                end
            end
            5, 6:
            begin
                push_event(random_item(CMD_RDY_ROSE));
                tick_run($urandom_range(0, 2));
                push_event(random_item(CMD_RDY_FELL));
            end
            default:
            begin
                repeat ($urandom_range(1, 3))
                    push_event(random_item(3'($urandom_range(0, 7))));
            end
        endcase
    endtask

    task automatic run_traffic(input int n);
        int goal;
        goal = sent + n;
        while (sent < goal)
            one_sequence();
    endtask

    initial
    begin : stimulus
        in_valid = 1'b0;
        in_data  = '0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        rst_n    = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        run_directed();

        set_timeout(16'd2);
        run_traffic(110);
        set_timeout(16'hFFFF);
        run_traffic(110);
        set_timeout(16'd0);
        calm = 1'b1;
        run_traffic(110);
        calm = 1'b0;
        set_timeout(16'd1);
        run_traffic(110);
        set_timeout(16'd9);
        run_traffic(110);
        set_timeout(16'd40);
        run_traffic(110);
        run_traffic(20);

        drain();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
